// ===== sv/rgb_to_cie_xy_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_to_cie_xy assertion macros
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_CIE_XY_ASSERT_SVH
`define RGB_TO_CIE_XY_ASSERT_SVH

// Same-cycle implication
`define RGBXY_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgb_to_cie_xy: same-cycle check failed");

// Next-cycle implication
`define RGBXY_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgb_to_cie_xy: next-cycle check failed");

`endif

// ===== sv/rgbxy_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbxy_pkg
// Shared widths, payload types, matrix coefficients and the sRGB
// linearization table generator for the RGB to CIE xy converter.
// ----------------------------------------------------------------------------
package rgbxy_pkg;

    // Fraction bits of the linear values and of the chromaticity outputs
    localparam int FRAC_BITS = 16;

    localparam int LANES  = 3;                  // red, green, blue
    localparam int ROWS   = 3;                  // X, Y, Z
    localparam int LIN_W  = FRAC_BITS + 1;      // linear value, 1.0 inclusive
    localparam int COEF_W = 20;                 // largest coefficient < 2^20
    localparam int PROD_W = LIN_W + COEF_W;
    localparam int SUM_W  = FRAC_BITS + 22;     // X+Y+Z < 2^22 * 2^FRAC_BITS
    localparam int QUO_W  = FRAC_BITS + 1;      // quotient bits incl. rounding bit

    // Lane order
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    // Matrix rows
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;

    // Wide-gamut RGB to XYZ matrix, millionths, [row][lane]
    localparam logic [COEF_W-1:0] MATRIX [ROWS][LANES] = '{
        '{20'd649926, 20'd103455, 20'd197109},
        '{20'd234327, 20'd743075, 20'd22598},
        '{20'd0,      20'd53077,  20'd1035763}
    };

    // Q1.31 constants for the table generator
    localparam logic [63:0] Q31_ONE = 64'd1 << 31;
    localparam logic [63:0] LIN_DEN = 64'd269025;

    // Input pixel transaction
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    // Result transaction
    typedef struct packed {
        logic [FRAC_BITS-1:0] chroma_x;
        logic [FRAC_BITS-1:0] chroma_y;
        logic                 undefined_flag;
    } chroma_t;

    // One lane's contributions to X, Y and Z
    typedef logic [ROWS-1:0][PROD_W-1:0] lane_prod_t;

    // Stage enables handed to a lane
    typedef struct packed {
        logic lookup;
        logic product;
    } lane_en_t;

    // Stage enables handed to the merge stage
    typedef struct packed {
        logic sum;
        logic total;
    } merge_en_t;

    // Q1.31 multiply with round half up
    function automatic logic [63:0] mul31(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // q^5 in Q1.31
    function automatic logic [63:0] pow5_31(input logic [63:0] q);
        logic [63:0] p;
        p = q;
        for (int i = 0; i < 4; i++) begin
            p = mul31(p, q);
        end
        return p;
    endfunction

    // Linearized sRGB code v as unsigned Q1.FRAC_BITS; elaboration only
    function automatic logic [LIN_W-1:0] lin_entry(input int unsigned v);
        logic [63:0] vv;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] val;
        vv = 64'(v);
        // Linear segment of the curve
        if (vv * 64'd100000 <= 64'd1031475) begin
            return LIN_W'((vv * 64'd10 * (64'd1 << FRAC_BITS) + 64'd16473) / 64'd32946);
        end
        // Power segment: t^2 * fifthroot(t^2)
        t   = (((vv * 64'd1000 + 64'd14025) << 31) + (LIN_DEN / 2)) / LIN_DEN;
        s   = mul31(t, t);
        lo  = '0;
        hi  = Q31_ONE;
        mid = '0;
        for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow5_31(mid) <= s) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        val = mul31(s, lo);
        return LIN_W'((val + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
    endfunction

endpackage

// ===== sv/rgb_to_cie_xy.sv =====
// ----------------------------------------------------------------------------
// rgb_to_cie_xy
// sRGB pixel to CIE 1931 xy chromaticity over a wide-gamut matrix.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one 8-bit RGB pixel per
//   transaction; output channel m_valid/m_ready/m_data returns chroma_x and
//   chroma_y as unsigned Q0.FRAC_BITS plus undefined_flag, one result per
//   pixel, in order.
//   Pipeline stages, in order: table lookup, matrix multiply, row sums,
//   total, one divider stage per quotient bit (FRAC_BITS+1), and the
//   rounding/output register. Throughput is one pixel per cycle while
//   m_ready keeps the output moving; the divider is fully pipelined and
//   every stage takes a new transaction each cycle unless it is stalled.
//   A black pixel (X+Y+Z zero) gives zero chromaticity with undefined_flag.
//   Reset (aresetn low, synchronous) empties the pipeline; no clearing pass.
//   When m_ready is low the result holds and the stages behind it keep
//   filling any empty slot; s_ready falls only once every stage is occupied.
// ----------------------------------------------------------------------------
`include "rgb_to_cie_xy_assert.svh"

module rgb_to_cie_xy
    import rgbxy_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  pixel_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output chroma_t m_data
);

    // Pipeline stage indices
    localparam int STG_LOOKUP  = 0;
    localparam int STG_PRODUCT = 1;
    localparam int STG_SUM     = 2;
    localparam int STG_TOTAL   = 3;
    localparam int STG_DIV     = 4;
    localparam int STG_OUT     = STG_DIV + QUO_W;
    localparam int NSTG        = STG_OUT + 1;

    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  vld_next;
    logic [NSTG-1:0]  adv;
    lane_en_t         lane_en;
    merge_en_t        merge_en;
    lane_prod_t       prod_r;
    lane_prod_t       prod_g;
    lane_prod_t       prod_b;
    logic [SUM_W-1:0] num_x;
    logic [SUM_W-1:0] num_y;
    logic [SUM_W-1:0] den;
    logic             black;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             flag_reg [QUO_W];
    logic [QUO_W:0]   rnd_x;
    logic [QUO_W:0]   rnd_y;
    logic [FRAC_BITS-1:0] cx;
    logic [FRAC_BITS-1:0] cy;
    chroma_t          out_reg;

    // Stage k moves when any stage from k onward is empty or the sink takes
    for (genvar k = 0; k < NSTG; k++) begin : g_adv
        assign adv[k] = m_ready | ~(&vld_reg[NSTG-1:k]);
    end

    // Valid bits follow the data
    always_comb begin
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[STG_LOOKUP];
    assign m_valid = vld_reg[STG_OUT];

    assign lane_en.lookup  = adv[STG_LOOKUP];
    assign lane_en.product = adv[STG_PRODUCT];
    assign merge_en.sum    = adv[STG_SUM];
    assign merge_en.total  = adv[STG_TOTAL];

    // Channel lanes
    rgbxy_lane #(.LANE(LANE_RED)) u_lane_r (
        .aclk (aclk),
        .en   (lane_en),
        .chan (s_data.red_in),
        .prod (prod_r)
    );

    rgbxy_lane #(.LANE(LANE_GREEN)) u_lane_g (
        .aclk (aclk),
        .en   (lane_en),
        .chan (s_data.green_in),
        .prod (prod_g)
    );

    rgbxy_lane #(.LANE(LANE_BLUE)) u_lane_b (
        .aclk (aclk),
        .en   (lane_en),
        .chan (s_data.blue_in),
        .prod (prod_b)
    );

    // Lane merge
    rgbxy_merge u_merge (
        .aclk   (aclk),
        .en     (merge_en),
        .prod_r (prod_r),
        .prod_g (prod_g),
        .prod_b (prod_b),
        .num_x  (num_x),
        .num_y  (num_y),
        .den    (den),
        .black  (black)
    );

    // Divider
    rgbxy_div u_div (
        .aclk  (aclk),
        .adv   (adv[STG_DIV +: QUO_W]),
        .num_x (num_x),
        .num_y (num_y),
        .den   (den),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    // Black flag travels alongside the divider stages
    for (genvar k = 0; k < QUO_W; k++) begin : g_flag
        always_ff @(posedge aclk) begin
            if (adv[STG_DIV+k]) begin
                if (k == 0) begin
                    flag_reg[k] <= black;
                end else begin
                    flag_reg[k] <= flag_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Round half up, saturate at all ones
    assign rnd_x = ((QUO_W+1)'(quo_x) + 1'b1) >> 1;
    assign rnd_y = ((QUO_W+1)'(quo_y) + 1'b1) >> 1;
    assign cx    = rnd_x[FRAC_BITS] ? '1 : rnd_x[FRAC_BITS-1:0];
    assign cy    = rnd_y[FRAC_BITS] ? '1 : rnd_y[FRAC_BITS-1:0];

    // Output register
    always_ff @(posedge aclk) begin
        if (adv[STG_OUT]) begin
            out_reg.chroma_x       <= flag_reg[QUO_W-1] ? '0 : cx;
            out_reg.chroma_y       <= flag_reg[QUO_W-1] ? '0 : cy;
            out_reg.undefined_flag <= flag_reg[QUO_W-1];
        end
    end

    assign m_data = out_reg;

    // Checks
    `RGBXY_ASSERT_IMP(a_black_zero, m_valid && m_data.undefined_flag,
        m_data.chroma_x == '0 && m_data.chroma_y == '0)
    `RGBXY_ASSERT_IMP(a_ready_full, !s_ready, (&vld_reg) && !m_ready)
    `RGBXY_ASSERT_NXT(a_accept_lands, s_valid && s_ready, vld_reg[STG_LOOKUP])

endmodule

// ===== sv/rgbxy_lane.sv =====
// ----------------------------------------------------------------------------
// rgbxy_lane
// One color channel: inverse-gamma table lookup, then the three matrix
// products of that channel's column.
// ----------------------------------------------------------------------------
module rgbxy_lane
    import rgbxy_pkg::*;
#(
    parameter int LANE = LANE_RED
) (
    input  logic       aclk,
    input  lane_en_t   en,
    input  logic [7:0] chan,
    output lane_prod_t prod
);

    logic [LIN_W-1:0] rom_tbl [256];
    logic [LIN_W-1:0] lin_reg;
    lane_prod_t       prod_reg;

    // Constant linearization table, built at elaboration
    for (genvar i = 0; i < 256; i++) begin : g_rom
        localparam logic [LIN_W-1:0] ENTRY = lin_entry(i);
        assign rom_tbl[i] = ENTRY;
    end

    // Table lookup
    always_ff @(posedge aclk) begin
        if (en.lookup) begin
            lin_reg <= rom_tbl[chan];
        end
    end

    // Column products, one multiplier per matrix row
    for (genvar r = 0; r < ROWS; r++) begin : g_mul
        always_ff @(posedge aclk) begin
            if (en.product) begin
                prod_reg[r] <= PROD_W'(lin_reg) * PROD_W'(MATRIX[r][LANE]);
            end
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/rgbxy_merge.sv =====
// ----------------------------------------------------------------------------
// rgbxy_merge
// Combines the lane products into X, Y, Z, then forms X+Y+Z and the
// black-pixel flag.
// ----------------------------------------------------------------------------
module rgbxy_merge
    import rgbxy_pkg::*;
(
    input  logic             aclk,
    input  merge_en_t        en,
    input  lane_prod_t       prod_r,
    input  lane_prod_t       prod_g,
    input  lane_prod_t       prod_b,
    output logic [SUM_W-1:0] num_x,
    output logic [SUM_W-1:0] num_y,
    output logic [SUM_W-1:0] den,
    output logic             black
);

    logic [SUM_W-1:0] x_reg;
    logic [SUM_W-1:0] y_reg;
    logic [SUM_W-1:0] z_reg;
    logic [SUM_W-1:0] numx_reg;
    logic [SUM_W-1:0] numy_reg;
    logic [SUM_W-1:0] den_reg;
    logic [SUM_W-1:0] total;
    logic             black_reg;

    // Row sums across the lanes
    always_ff @(posedge aclk) begin
        if (en.sum) begin
            x_reg <= SUM_W'(prod_r[ROW_X]) + SUM_W'(prod_g[ROW_X]) + SUM_W'(prod_b[ROW_X]);
            y_reg <= SUM_W'(prod_r[ROW_Y]) + SUM_W'(prod_g[ROW_Y]) + SUM_W'(prod_b[ROW_Y]);
            z_reg <= SUM_W'(prod_r[ROW_Z]) + SUM_W'(prod_g[ROW_Z]) + SUM_W'(prod_b[ROW_Z]);
        end
    end

    assign total = x_reg + y_reg + z_reg;

    // Divisor and numerators for the divider
    always_ff @(posedge aclk) begin
        if (en.total) begin
            numx_reg  <= x_reg;
            numy_reg  <= y_reg;
            den_reg   <= total;
            black_reg <= (total == '0);
        end
    end

    assign num_x = numx_reg;
    assign num_y = numy_reg;
    assign den   = den_reg;
    assign black = black_reg;

endmodule

// ===== sv/rgbxy_div.sv =====
// ----------------------------------------------------------------------------
// rgbxy_div
// Pipelined restoring divider, one quotient bit per stage, computing
// X/S and Y/S side by side over a shared divisor pipeline.
// ----------------------------------------------------------------------------
module rgbxy_div
    import rgbxy_pkg::*;
(
    input  logic             aclk,
    input  logic [QUO_W-1:0] adv,
    input  logic [SUM_W-1:0] num_x,
    input  logic [SUM_W-1:0] num_y,
    input  logic [SUM_W-1:0] den,
    output logic [QUO_W-1:0] quo_x,
    output logic [QUO_W-1:0] quo_y
);

    logic [SUM_W-1:0] remx_reg [QUO_W];
    logic [SUM_W-1:0] remy_reg [QUO_W];
    logic [SUM_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] qx_reg   [QUO_W];
    logic [QUO_W-1:0] qy_reg   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [SUM_W-1:0] remx_in;
        logic [SUM_W-1:0] remy_in;
        logic [SUM_W-1:0] den_in;
        logic [QUO_W-1:0] qx_in;
        logic [QUO_W-1:0] qy_in;
        logic [SUM_W:0]   shx;
        logic [SUM_W:0]   shy;
        logic             gex;
        logic             gey;
        logic [SUM_W-1:0] remx_next;
        logic [SUM_W-1:0] remy_next;

        // Stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign remx_in = num_x;
            assign remy_in = num_y;
            assign den_in  = den;
            assign qx_in   = '0;
            assign qy_in   = '0;
        end else begin : g_next
            assign remx_in = remx_reg[k-1];
            assign remy_in = remy_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
        end

        // Shift, compare, conditional subtract
        assign shx       = {remx_in, 1'b0};
        assign shy       = {remy_in, 1'b0};
        assign gex       = (shx >= {1'b0, den_in});
        assign gey       = (shy >= {1'b0, den_in});
        assign remx_next = gex ? SUM_W'(shx - {1'b0, den_in}) : SUM_W'(shx);
        assign remy_next = gey ? SUM_W'(shy - {1'b0, den_in}) : SUM_W'(shy);

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                remx_reg[k] <= remx_next;
                remy_reg[k] <= remy_next;
                den_reg[k]  <= den_in;
                qx_reg[k]   <= {qx_in[QUO_W-2:0], gex};
                qy_reg[k]   <= {qy_in[QUO_W-2:0], gey};
            end
        end
    end

    assign quo_x = qx_reg[QUO_W-1];
    assign quo_y = qy_reg[QUO_W-1];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rgb_to_cie_xy
// Drives RGB pixel transactions through the converter under random sender
// bursts and receiver stalls, predicts each chromaticity result from a local
// linearization table and matrix, and compares every result in order.
// ----------------------------------------------------------------------------
module tb;
    import rgbxy_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;   // far beyond the slowest correct run
    localparam int DRAIN_CYCLES = 40;       // longer than the pipeline latency
    localparam int REPORT_MAX   = 10;

    // Gamma segment constants, Q1.31
    localparam logic [63:0] Q31_UNIT  = 64'd1 << 31;
    localparam logic [63:0] GAMMA_DEN = 64'd269025;

    // RGB to XYZ coefficients in millionths
    localparam logic [63:0] XR = 64'd649926, XG = 64'd103455, XB = 64'd197109;
    localparam logic [63:0] YR = 64'd234327, YG = 64'd743075, YB = 64'd22598;
    localparam logic [63:0] ZG = 64'd53077,  ZB = 64'd1035763;

    // Corners of the color cube, the linear/power boundary and bit patterns
    localparam pixel_t CORNER_PIXELS [20] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
        '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},
        '{8'd0,   8'd0,   8'd1},   '{8'd10,  8'd10,  8'd10},
        '{8'd11,  8'd11,  8'd11},  '{8'd10,  8'd11,  8'd0},
        '{8'd0,   8'd10,  8'd11},  '{8'd128, 8'd128, 8'd128},
        '{8'd170, 8'd85,  8'd170}, '{8'd85,  8'd170, 8'd85},
        '{8'd1,   8'd255, 8'd1},   '{8'd254, 8'd1,   8'd254}
    };

    typedef enum logic {
        RX_ALWAYS,
        RX_PATTERN
    } rx_mode_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    pixel_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    chroma_t m_data;

    // Receiver control, written by the tests at clock edges
    rx_mode_t    rx_mode        = RX_ALWAYS;
    int unsigned rx_max_stall   = 6;
    int unsigned rx_hold_len    = 0;
    logic        rx_hold_toggle = 1'b0;

    // Receiver private state
    logic        rx_hold_seen;
    int unsigned rx_hold_left;
    int unsigned rx_run_left;

    logic [FRAC_BITS:0] lin_tab [256];
    chroma_t            expected_chroma_q [$];
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count    = 0;

    rgb_to_cie_xy u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Q1.31 product, rounded half up
    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    function automatic logic [63:0] q31_fifth_power(input logic [63:0] q);
        logic [63:0] acc;
        acc = q;
        for (int k = 0; k < 4; k++) begin
            acc = q31_mul(acc, q);
        end
        return acc;
    endfunction

    // Linear light value of one sRGB code, Q1.FRAC_BITS
    function automatic logic [FRAC_BITS:0] srgb_to_linear(input int unsigned code);
        logic [63:0] v;
        logic [63:0] t;
        logic [63:0] t_sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lin;
        v = 64'(code);
        // Straight segment near black
        if (v * 64'd100000 <= 64'd1031475) begin
            return (FRAC_BITS+1)'((v * 64'd10 * (64'd1 << FRAC_BITS) + 64'd16473) / 64'd32946);
        end
        // t^2.4 as t^2 times the fifth root of t^2, root found by bisection
        t    = (((v * 64'd1000 + 64'd14025) << 31) + (GAMMA_DEN / 2)) / GAMMA_DEN;
        t_sq = q31_mul(t, t);
        lo   = '0;
        hi   = Q31_UNIT;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 2;
            if (q31_fifth_power(mid) <= t_sq) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        lin = q31_mul(t_sq, lo);
        return (FRAC_BITS+1)'((lin + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
    endfunction

    // num/den as Q0.FRAC_BITS, rounded half up and saturated below 1.0
    function automatic logic [FRAC_BITS-1:0] ratio_q(input logic [63:0] num,
                                                     input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = num;
        for (int k = 0; k < FRAC_BITS + 1; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 64'd1) >> 1;
        if (quo > (64'd1 << FRAC_BITS) - 64'd1) begin
            quo = (64'd1 << FRAC_BITS) - 64'd1;
        end
        return quo[FRAC_BITS-1:0];
    endfunction

    function automatic chroma_t predict_chroma(input pixel_t p);
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] cie_x;
        logic [63:0] cie_y;
        logic [63:0] cie_z;
        logic [63:0] total;
        chroma_t     res;
        r     = 64'(lin_tab[p.red_in]);
        g     = 64'(lin_tab[p.green_in]);
        b     = 64'(lin_tab[p.blue_in]);
        cie_x = XR * r + XG * g + XB * b;
        cie_y = YR * r + YG * g + YB * b;
        cie_z = ZG * g + ZB * b;
        total = cie_x + cie_y + cie_z;
        res   = '0;
        // Black: chromaticity undefined, zeros plus flag
        if (total == 0) begin
            res.undefined_flag = 1'b1;
        end else begin
            res.chroma_x = ratio_q(cie_x, total);
            res.chroma_y = ratio_q(cie_y, total);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input pixel_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        expected_chroma_q.push_back(predict_chroma(p));
    endtask

    task automatic idle_cycles(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chroma_q.size() != 0);
    endtask

    function automatic logic [7:0] random_channel(input bit dark);
        if (dark) begin
            return ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 14));
        end
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 12));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel(input bit dark);
        pixel_t p;
        p.red_in   = random_channel(dark);
        p.green_in = random_channel(dark);
        p.blue_in  = random_channel(dark);
        return p;
    endfunction

    // Random bursts separated by random gaps; some bursts run back to back
    task automatic stream_pixels(input int unsigned count, input bit dark,
                                 input int unsigned max_gap);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_pixel(random_pixel(dark));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
            if (gap != 0) begin
                idle_cycles(gap);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_corner_pixels();
        rx_mode <= RX_ALWAYS;
        foreach (CORNER_PIXELS[k]) begin
            send_pixel(CORNER_PIXELS[k]);
        end
        wait_drained();
    endtask

    task automatic test_random_stream();
        rx_mode      <= RX_PATTERN;
        rx_max_stall <= 6;
        stream_pixels(240, 1'b0, 6);
        // sender pauses here until every result is back
        wait_drained();
        stream_pixels(240, 1'b0, 3);
        wait_drained();
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_full_pipeline();
        rx_hold_len    <= 300;
        rx_hold_toggle <= ~rx_hold_toggle;
        for (int k = 0; k < 120; k++) begin
            send_pixel(random_pixel(1'b0));
        end
        wait_drained();
    endtask

    task automatic test_dark_pixels();
        rx_mode      <= RX_PATTERN;
        rx_max_stall <= 12;
        stream_pixels(80, 1'b1, 8);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: always ready, random ready/stall runs, or a long hold on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_hold_seen = rx_hold_toggle;
            rx_hold_left = 0;
            rx_run_left  = 0;
        end else if (rx_hold_toggle != rx_hold_seen) begin
            rx_hold_seen = rx_hold_toggle;
            rx_hold_left = rx_hold_len;
            m_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            m_ready <= 1'b1;
        end else if (rx_run_left == 0) begin
            m_ready     <= !m_ready;
            rx_run_left = m_ready ? $urandom_range(1, rx_max_stall) : $urandom_range(1, 12);
        end else begin
            rx_run_left--;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        chroma_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chroma_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result transaction: x=%0d y=%0d flag=%0b",
                             m_data.chroma_x, m_data.chroma_y, m_data.undefined_flag);
                end
            end else begin
                want = expected_chroma_q.pop_front();
                if (m_data.chroma_x !== want.chroma_x ||
                    m_data.chroma_y !== want.chroma_y ||
                    m_data.undefined_flag !== want.undefined_flag) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: expected x=%0d y=%0d flag=%0b, got x=%0d y=%0d flag=%0b",
                                 want.chroma_x, want.chroma_y, want.undefined_flag,
                                 m_data.chroma_x, m_data.chroma_y, m_data.undefined_flag);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int k = 0; k < 256; k++) begin
            lin_tab[k] = srgb_to_linear(k);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_pixels();
        test_random_stream();
        test_full_pipeline();
        test_dark_pixels();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_chroma_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== rgb_to_cie_xy.f =====
+incdir+sv
sv/rgbxy_pkg.sv
sv/rgbxy_lane.sv
sv/rgbxy_merge.sv
sv/rgbxy_div.sv
sv/rgb_to_cie_xy.sv
test/tb.sv
